FILE: hw/rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Request and status codes shared by the double-ended queue engine.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int VALUE_BITS = 32;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_PEEK_FRONT = 3'd4,
        ACT_PEEK_BACK  = 3'd5,
        ACT_CLEAR      = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ITEM  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

endpackage

FILE: hw/rtl/deq_store.sv
// ----------------------------------------------------------------------------
// deq_store
// Item ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module deq_store #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/double_ended_queue_engine.sv
// ----------------------------------------------------------------------------
// double_ended_queue_engine
// Bounded double-ended queue of item handles kept in a ring store with a
// front pointer and an entry count.
//
//   channel   | signals                        | handshake
//   ----------+--------------------------------+------------------------------
//   request   | action, item_value             | start high while busy low
//   result    | status, result_value           | done high for one cycle
//
// one item is taken every cycle; its result shows in the cycle after acceptance
// the ring store is read and written at the accepting edge, pointers move then
// busy stays low, the receiver cannot stall, so nothing ever backs up
// reset clears the pointer and count; stored items are undefined until pushed
// ----------------------------------------------------------------------------
module double_ended_queue_engine #(
    parameter int CAPACITY  = 256,
    parameter int ITEM_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [2:0]  action,
    input  logic [31:0] item_value,
    output logic        busy,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] result_value
);

    import deq_pkg::*;

    localparam int PTR_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int STORE_BITS = (ITEM_BITS < VALUE_BITS) ? ITEM_BITS : VALUE_BITS;

    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [CNT_W:0]   CAP_EXT  = (CNT_W + 1)'(CAPACITY);

    logic [PTR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg;
    status_t          status_reg, status_next;

    logic             accept;
    action_t          act;
    logic             is_empty, is_full;
    logic [PTR_W-1:0] front_dec, front_inc, back_pos, last_pos;
    logic [CNT_W:0]   back_sum;

    logic                  wr_en, rd_en;
    logic [PTR_W-1:0]      wr_addr, rd_addr;
    logic [STORE_BITS-1:0] rd_data;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign act    = action_t'(action);

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CAP_CNT);

    // ring neighbors of the front and the slot past the back
    assign front_dec = (front_reg == '0) ? LAST_POS : front_reg - 1'b1;
    assign front_inc = (front_reg == LAST_POS) ? '0 : front_reg + 1'b1;
    assign back_sum  = (CNT_W + 1)'(front_reg) + (CNT_W + 1)'(count_reg);

    always_comb
    begin
        if (back_sum >= CAP_EXT)
        begin
            back_pos = PTR_W'(back_sum - CAP_EXT);
        end
        else
        begin
            back_pos = PTR_W'(back_sum);
        end
    end

    assign last_pos = (back_pos == '0) ? LAST_POS : back_pos - 1'b1;

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        wr_en       = 1'b0;
        wr_addr     = back_pos;
        rd_en       = 1'b0;
        rd_addr     = front_reg;
        unique case (act)
            ACT_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en      = accept;
                    wr_addr    = front_dec;
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en      = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_POP_FRONT, ACT_PEEK_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    status_next = ST_ITEM;
                    rd_en       = accept;
                    if (act == ACT_POP_FRONT)
                    begin
                        front_next = front_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            ACT_POP_BACK, ACT_PEEK_BACK:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    status_next = ST_ITEM;
                    rd_en       = accept;
                    rd_addr     = last_pos;
                    if (act == ACT_POP_BACK)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            ACT_CLEAR:
            begin
                front_next = '0;
                count_next = '0;
            end
            default:
            begin
                // unused code: no change
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                front_reg  <= front_next;
                count_reg  <= count_next;
                status_reg <= status_next;
            end
        end
    end

    deq_store #(
        .DEPTH  (CAPACITY),
        .WIDTH  (STORE_BITS),
        .ADDR_W (PTR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item_value[STORE_BITS-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign done         = done_reg;
    assign status       = status_reg;
    assign result_value = (status_reg == ST_ITEM) ? VALUE_BITS'(rd_data) : '0;

endmodule

FILE: tb/tb_double_ended_queue_engine.sv
// ----------------------------------------------------------------------------
// tb_double_ended_queue_engine
// Self-checking bench for the double-ended queue engine. A short directed
// table covers empty corners, both ends, clear and the unused code, then random
// fill, drain and mixed phases push the ring through its wrap and its full state.
// Results are checked against a local ring predictor or a pinned row's values.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_engine;

    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int CAPACITY = 256;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CALM_ITEMS = 150;
    localparam logic [2:0] ACT_UNUSED = 3'd7;
    localparam int DIR_ROWS = 24;

    localparam int PH_FILL  = 0;
    localparam int PH_DRAIN = 1;
    localparam int PH_MIXED = 2;

    typedef struct packed {
        status_t     st;
        logic [31:0] res;
    } result_t;

    // one request; pinned rows carry a hand-typed expected result
    typedef struct packed {
        logic [2:0]  act;
        logic [31:0] val;
        logic        pinned;
        status_t     st;
        logic [31:0] res;
    } request_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic [2:0]  action;
    logic [31:0] item_value;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [31:0] result_value;

    logic [31:0] deque_store [CAPACITY];
    int          head_idx;
    int          fill_cnt;

    request_t    sent_requests [$];
    result_t     pending_results [$];
    request_t    dir_rows [DIR_ROWS];
    int          errors;
    int          items_sent;

    double_ended_queue_engine #(
        .CAPACITY  (CAPACITY),
        .ITEM_BITS (32)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .action       (action),
        .item_value   (item_value),
        .busy         (busy),
        .done         (done),
        .status       (status),
        .result_value (result_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    function automatic result_t deque_apply(input logic [2:0] act, input logic [31:0] val);
        result_t r;
        int      slot;
        r.st  = ST_OK;
        r.res = '0;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (fill_cnt >= CAPACITY)
                    r.st = ST_FULL;
                else
                begin
                    if (act == ACT_PUSH_FRONT)
                    begin
                        head_idx = (head_idx + CAPACITY - 1) % CAPACITY;
                        slot = head_idx;
                    end
                    else
                        slot = (head_idx + fill_cnt) % CAPACITY;
                    deque_store[slot] = val;
                    fill_cnt++;
                end
            end
            ACT_POP_FRONT, ACT_PEEK_FRONT, ACT_POP_BACK, ACT_PEEK_BACK:
            begin
                if (fill_cnt == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    if (act == ACT_POP_FRONT || act == ACT_PEEK_FRONT)
                        slot = head_idx;
                    else
                        slot = (head_idx + fill_cnt - 1) % CAPACITY;
                    r.st  = ST_ITEM;
                    r.res = deque_store[slot];
                    if (act == ACT_POP_FRONT)
                        head_idx = (head_idx + 1) % CAPACITY;
                    if (act == ACT_POP_FRONT || act == ACT_POP_BACK)
                        fill_cnt--;
                end
            end
            ACT_CLEAR:
            begin
                head_idx = 0;
                fill_cnt = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // predict at the accepting edge, check results as they strobe out
    always @(posedge clk)
    begin
        request_t req;
        result_t  want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                req  = sent_requests.pop_front();
                want = deque_apply(action, item_value);
                if (req.pinned)
                    want = '{st: req.st, res: req.res};
                pending_results.push_back(want);
            end
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no item pending: status %0d value %h",
                             $time, status, result_value);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.st)
                    begin
                        errors++;
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.st, status);
                    end
                    if (result_value !== want.res)
                    begin
                        errors++;
                        $display("%0t: result_value mismatch: expected %h actual %h",
                                 $time, want.res, result_value);
                    end
                end
            end
        end
    end

    task automatic send_item(input request_t req);
        start      <= 1'b1;
        action     <= req.act;
        item_value <= req.val;
        sent_requests.push_back(req);
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    task automatic maybe_idle(input int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    function automatic request_t random_request(input int push_pct, input int clear_pct);
        request_t req;
        int       pick;
        req = '0;
        pick = $urandom_range(15);
        if (pick == 0)
            req.val = 32'h0;
        else if (pick == 1)
            req.val = 32'hFFFF_FFFF;
        else
            req.val = $urandom;
        if ($urandom_range(99) < push_pct)
            req.act = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
        else
        begin
            pick = $urandom_range(99);
            if (pick < clear_pct)
                req.act = ACT_CLEAR;
            else if (pick < clear_pct + 2)
                req.act = ACT_UNUSED;
            else
                case ($urandom_range(3))
                    0: req.act = ACT_POP_FRONT;
                    1: req.act = ACT_POP_BACK;
                    2: req.act = ACT_PEEK_FRONT;
                    default: req.act = ACT_PEEK_BACK;
                endcase
        end
        return req;
    endfunction

    // fill runs to full and keeps pushing a while, drain runs to empty
    task automatic run_phase(input int kind, input int idle_pct);
        int n;
        int extra;
        int push_pct;
        int clear_pct;
        n = 0;
        extra = $urandom_range(10, 30);
        clear_pct = 0;
        case (kind)
            PH_FILL:  push_pct = 90;
            PH_DRAIN: push_pct = 10;
            default:
            begin
                push_pct = 50;
                clear_pct = 3;
                extra = $urandom_range(80, 200);
            end
        endcase
        if (kind == PH_FILL)
            while (fill_cnt < CAPACITY && n < 800)
            begin
                maybe_idle(idle_pct);
                send_item(random_request(push_pct, clear_pct));
                n++;
            end
        else if (kind == PH_DRAIN)
            while (fill_cnt > 0 && n < 800)
            begin
                maybe_idle(idle_pct);
                send_item(random_request(push_pct, clear_pct));
                n++;
            end
        repeat (extra)
        begin
            maybe_idle(idle_pct);
            send_item(random_request(push_pct, clear_pct));
        end
    endtask

    initial
    begin
        int guard;
        int idle_pct;
        errors     = 0;
        items_sent = 0;
        head_idx   = 0;
        fill_cnt   = 0;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        action     <= ACT_PUSH_FRONT;
        item_value <= '0;

        dir_rows = '{
            '{ACT_POP_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
            '{ACT_POP_BACK,   32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
            '{ACT_PEEK_FRONT, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
            '{ACT_PEEK_BACK,  32'hFFFF_FFFF, 1'b1, ST_EMPTY, 32'h0000_0000},
            '{ACT_UNUSED,     32'hFFFF_FFFF, 1'b1, ST_OK,    32'h0000_0000},
            '{ACT_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, ST_OK,    32'h0000_0000},
            '{ACT_PUSH_BACK,  32'h0000_0000, 1'b1, ST_OK,    32'h0000_0000},
            '{ACT_PEEK_FRONT, 32'h0000_0000, 1'b1, ST_ITEM,  32'hFFFF_FFFF},
            '{ACT_PEEK_BACK,  32'h0000_0000, 1'b1, ST_ITEM,  32'h0000_0000},
            '{ACT_PUSH_FRONT, 32'h0000_0001, 1'b1, ST_OK,    32'h0000_0000},
            '{ACT_PUSH_BACK,  32'h8000_0000, 1'b1, ST_OK,    32'h0000_0000},
            '{ACT_POP_BACK,   32'h0000_0000, 1'b1, ST_ITEM,  32'h8000_0000},
            '{ACT_POP_FRONT,  32'h0000_0000, 1'b1, ST_ITEM,  32'h0000_0001},
            '{ACT_POP_FRONT,  32'h0000_0000, 1'b1, ST_ITEM,  32'hFFFF_FFFF},
            '{ACT_POP_BACK,   32'h0000_0000, 1'b1, ST_ITEM,  32'h0000_0000},
            '{ACT_POP_BACK,   32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
            '{ACT_PUSH_BACK,  32'h5A5A_5A5A, 1'b0, ST_OK,    32'h0000_0000},
            '{ACT_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0, ST_OK,    32'h0000_0000},
            '{ACT_CLEAR,      32'h0000_0000, 1'b1, ST_OK,    32'h0000_0000},
            '{ACT_PEEK_BACK,  32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
            '{ACT_PUSH_BACK,  32'h1234_5678, 1'b0, ST_OK,    32'h0000_0000},
            '{ACT_PEEK_FRONT, 32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000},
            '{ACT_UNUSED,     32'hDEAD_BEEF, 1'b1, ST_OK,    32'h0000_0000},
            '{ACT_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            maybe_idle(25);
            send_item(dir_rows[i]);
        end

        // random phases; idle rate varies so some stretches run back to back
        while (items_sent < RANDOM_ITEMS - CALM_ITEMS)
        begin
            case ($urandom_range(2))
                0: idle_pct = 0;
                1: idle_pct = 10;
                default: idle_pct = 35;
            endcase
            run_phase($urandom_range(2), idle_pct);
        end

        // closing stretch with no gaps
        repeat (CALM_ITEMS)
            send_item(random_request(50, 3));
        start <= 1'b0;

        guard = 0;
        while (pending_results.size() != 0 && guard < 100)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
